// ===== rtl/pwbt_pkg.sv =====
// Types, constants and the window share function of the pause window budget tracker.
`default_nettype none
package pwbt_pkg;

  localparam int TIME_W  = 48;
  localparam int WST_W   = 50;
  localparam int SHARE_W = 49;
  localparam int TOTAL_W = 36;
  localparam int REG_W   = 32;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 36'hF_FFFF_FFFF;
  localparam logic [REG_W-1:0]   DELAY_MAX = 32'hFFFF_FFFF;

  localparam logic [REG_W-1:0] WINDOW_RESET = 32'd1000000;
  localparam logic [REG_W-1:0] BUDGET_RESET = 32'd100000;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_WINDOW_LENGTH = 1'b0;
  localparam cfg_idx_t CFG_BUSY_BUDGET   = 1'b1;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic signed [WST_W-1:0] wstart_t;

  typedef struct packed {
    logic              op;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
    logic [TIME_W-1:0] now_time;
    logic [REG_W-1:0]  pause_length;
  } req_t;

  typedef struct packed {
    logic               within_budget;
    logic [TOTAL_W-1:0] window_total;
    logic [REG_W-1:0]   min_delay;
    logic               overflow;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_EXPIRE,
    ST_ADJ,
    ST_SUM,
    ST_QUERY,
    ST_FIN
  } state_t;

  function automatic logic [SHARE_W-1:0] share(input logic [TIME_W-1:0] st,
                                               input logic [TIME_W-1:0] en,
                                               input wstart_t w);
    wstart_t s;
    wstart_t e;
    wstart_t from;
    wstart_t diff;
    s    = signed'({2'b00, st});
    e    = signed'({2'b00, en});
    from = (s > w) ? s : w;
    diff = e - from;
    return (e > from) ? diff[SHARE_W-1:0] : '0;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pwbt_ram.sv =====
// Single-port-write, single-port-read synchronous memory with registered read data.
`default_nettype none
module pwbt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/pause_window_budget_tracker_unit.sv =====
// Top level: FIFO of busy periods in memory, expiry, window sum and pause delay walk.
// Add: expires old entries, stores the new period (dropping the oldest when full) and sums the window.
// Query: walks stored entries newest first, stopping at an expired entry or when the budget runs out.
// One item at a time; the next start is taken in the cycle done is high.
// The read address shared by the two memories walks one stored entry per cycle.
// Synchronous reset empties the FIFO and loads the default window and budget; done has no stall.
`default_nettype none
module pause_window_budget_tracker_unit
  import pwbt_pkg::*;
#(
  parameter int FIFO_DEPTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire req_t       req,
  output logic            done,
  output res_t            res,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire cfg_idx_t   cfg_index,
  input  wire logic [REG_W-1:0] cfg_data
);

  localparam int IDXW = (FIFO_DEPTH > 2) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNTW = $clog2(FIFO_DEPTH + 1);
  localparam logic [CNTW-1:0] DEPTH_C = CNTW'(FIFO_DEPTH);

  function automatic logic [IDXW-1:0] wrap(input logic [IDXW-1:0] a,
                                           input logic [CNTW-1:0] b);
    logic [CNTW:0] s;
    s = (CNTW+1)'(a) + (CNTW+1)'(b);
    if (s >= (CNTW+1)'(FIFO_DEPTH)) begin
      s = s - (CNTW+1)'(FIFO_DEPTH);
    end
    return s[IDXW-1:0];
  endfunction

  state_t state, state_next;

  req_t               req_r;
  logic [REG_W-1:0]   window_length, busy_budget;
  logic [IDXW-1:0]    head;
  logic [CNTW-1:0]    count;
  logic [CNTW-1:0]    lim;
  logic [CNTW-1:0]    k;
  logic [CNTW-1:0]    exp_n;
  wstart_t            w_r;
  logic [REG_W-1:0]   left_r;
  logic [TOTAL_W-1:0] total_r;
  logic [REG_W-1:0]   delay_r;
  logic               ovf_r;
  logic [SHARE_W-1:0] nd_r;
  logic               v1, v2;
  logic [SHARE_W-1:0] d2;
  logic [TIME_W-1:0]  en2;
  logic               ex2;

  logic               issue, fin;
  logic [IDXW-1:0]    rd_addr, wr_addr;
  logic               wr_en;
  logic [TIME_W-1:0]  start_q, end_q;
  logic               exp_hit;
  logic [CNTW-1:0]    e_tot;
  logic               q_stop;
  logic               ovf_now;
  logic [REG_W-1:0]   pause_c;
  logic [WST_W:0]     acc;
  logic signed [WST_W:0] r;

  pwbt_ram #(.WIDTH(TIME_W), .DEPTH(FIFO_DEPTH), .AW(IDXW)) u_starts (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (req_r.start_time),
    .rd_addr (rd_addr),
    .rd_data (start_q)
  );

  pwbt_ram #(.WIDTH(TIME_W), .DEPTH(FIFO_DEPTH), .AW(IDXW)) u_ends (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (req_r.end_time),
    .rd_addr (rd_addr),
    .rd_data (end_q)
  );

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);

  always_comb begin
    exp_hit = v1 && (signed'({2'b00, end_q}) <= w_r);
    e_tot   = exp_n + CNTW'(exp_hit);
    q_stop  = v2 && (ex2 || (d2 > SHARE_W'(left_r)));
    ovf_now = (count == DEPTH_C);
    pause_c = (req_r.pause_length > busy_budget) ? busy_budget : req_r.pause_length;
    acc     = (WST_W+1)'(total_r) + (WST_W+1)'(d2);
    r       = signed'({3'b000, en2}) - signed'((WST_W+1)'(left_r))
              - (WST_W+1)'(w_r);
    wr_en   = (state == ST_ADJ);
    wr_addr = ovf_now ? head : wrap(head, count);
    rd_addr = (state == ST_QUERY) ? wrap(head, lim - CNTW'(1) - k) : wrap(head, k);
  end

  always_comb begin
    state_next = state;
    fin        = 1'b0;
    issue      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_next = (req_r.op == OP_QUERY) ? ST_QUERY : ST_EXPIRE;
      end
      ST_EXPIRE: begin
        fin   = (lim == '0) || (v1 && (!exp_hit || e_tot == lim));
        issue = (k < lim);
        if (fin) begin
          state_next = ST_ADJ;
        end
      end
      ST_ADJ: begin
        state_next = ST_SUM;
      end
      ST_SUM: begin
        fin   = (k == lim) && !v1 && !v2;
        issue = (k < lim);
        if (fin) begin
          state_next = ST_FIN;
        end
      end
      ST_QUERY: begin
        fin   = q_stop || ((k == lim) && !v1 && !v2);
        issue = (k < lim);
        if (fin) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_RESET;
      busy_budget   <= BUDGET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WINDOW_LENGTH: window_length <= cfg_data;
        CFG_BUSY_BUDGET:   busy_budget   <= cfg_data;
        default:           window_length <= window_length;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      done  <= 1'b0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      k     <= '0;
    end else begin
      done <= (state == ST_FIN);
      v1   <= issue && !fin;
      v2   <= v1 && !fin;
      if (issue) begin
        k <= k + CNTW'(1);
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            req_r <= req;
          end
        end
        ST_SETUP: begin
          lim     <= count;
          k       <= '0;
          exp_n   <= '0;
          total_r <= '0;
          delay_r <= '0;
          ovf_r   <= 1'b0;
          if (req_r.op == OP_QUERY) begin
            w_r    <= signed'({2'b00, req_r.now_time}) + signed'(WST_W'(pause_c))
                      - signed'(WST_W'(window_length));
            left_r <= busy_budget - pause_c;
          end else begin
            w_r <= signed'({2'b00, req_r.end_time}) - signed'(WST_W'(window_length));
          end
        end
        ST_EXPIRE: begin
          nd_r  <= share(req_r.start_time, req_r.end_time, w_r);
          exp_n <= e_tot;
          if (fin) begin
            head  <= wrap(head, e_tot);
            count <= count - e_tot;
          end
        end
        ST_ADJ: begin
          total_r <= (nd_r > SHARE_W'(TOTAL_MAX)) ? TOTAL_MAX : nd_r[TOTAL_W-1:0];
          ovf_r   <= ovf_now;
          k       <= '0;
          if (ovf_now) begin
            head  <= wrap(head, CNTW'(1));
            lim   <= DEPTH_C - CNTW'(1);
            count <= DEPTH_C;
          end else begin
            lim   <= count;
            count <= count + CNTW'(1);
          end
        end
        ST_SUM: begin
          if (v2) begin
            total_r <= (acc > (WST_W+1)'(TOTAL_MAX)) ? TOTAL_MAX : acc[TOTAL_W-1:0];
          end
        end
        ST_QUERY: begin
          if (v2) begin
            if (ex2) begin
              delay_r <= '0;
            end else if (d2 > SHARE_W'(left_r)) begin
              if (r <= 0) begin
                delay_r <= '0;
              end else if (r > (WST_W+1)'(DELAY_MAX)) begin
                delay_r <= DELAY_MAX;
              end else begin
                delay_r <= r[REG_W-1:0];
              end
            end else begin
              left_r <= left_r - d2[REG_W-1:0];
            end
          end
        end
        ST_FIN: begin
          res.within_budget <= (req_r.op == OP_ADD) && (total_r <= TOTAL_W'(busy_budget));
          res.window_total  <= total_r;
          res.min_delay     <= delay_r;
          res.overflow      <= ovf_r;
        end
        default: begin
          k <= k;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      d2  <= share(start_q, end_q, w_r);
      en2 <= end_q;
      ex2 <= (signed'({2'b00, end_q}) <= w_r);
    end
  end

  a_done_after_fin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_FIN))
    else $error("done without a finishing step");

  a_start_goes_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted word did not make the block busy");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    done && res.overflow |-> count == DEPTH_C)
    else $error("overflow reported while FIFO not full");

  a_pipe_order: assert property (@(posedge clk) disable iff (rst)
    v2 |-> $past(v1))
    else $error("read pipeline stage without a read");

  a_query_fields: assert property (@(posedge clk) disable iff (rst)
    done && res.min_delay != '0 |-> res.window_total == '0 && !res.overflow)
    else $error("query result carries add fields");

endmodule
`default_nettype wire
